@@ src/rmsp_pkg.sv @@
// Shared types, constants and codes of the read memory size profiler.
package rmsp_pkg;

  localparam int ADDR_BITS   = 16;
  localparam int STACK_DEPTH = 64;
  localparam int MAX_LENGTH  = 4095;

  localparam int LEN_W   = 12;
  localparam int FID_W   = 16;
  localparam int TS_W    = 32;
  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  localparam int IN_W  = 80;
  localparam int OUT_W = 120;

  typedef enum logic [2:0] {
    MODE_CALL  = 3'd0,
    MODE_RET   = 3'd1,
    MODE_READ  = 3'd2,
    MODE_WRITE = 3'd3,
    MODE_ADD   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    STAT_REC   = 2'd0,
    STAT_OVF   = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [FID_W-1:0] func;
    logic [TS_W-1:0]  ts;
    logic [31:0]      rms;
    logic [31:0]      cost;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  typedef struct packed {
    logic [31:0]      cost;
    logic [31:0]      rms;
    logic [TS_W-1:0]  ts;
    logic [FID_W-1:0] func_id;
    logic [1:0]       status;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RET_A,
    ST_RET_B,
    ST_ADD,
    ST_TOP,
    ST_B_ISSUE,
    ST_B_EVAL,
    ST_S_CHK,
    ST_WB,
    ST_EMIT
  } state_t;

endpackage

@@ src/rmsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rmsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/read_memory_size_profiler_top.sv @@
// Top level of the read memory size profiler engine.
//
// channel | dir | word fields (low bit up)
// s_*     | in  | mode[2:0] addr[18:3] length[30:19] func_id[46:31] cost[78:47]
// m_*     | out | status[1:0] rec_func_id[17:2] rec_ts[49:18] rec_rms[81:50]
//         |     | rec_cost[113:82]
//
// Call: accepted in idle. Add: top frame read, then write-back. Return: top frame read, then
// a fold into the parent frame above depth one, then record hand-off. Write: per byte a shadow
// memory read, then a stamp write. Read: the same, between top frame fetch and write-back (on
// an empty stack, record hand-off instead), plus a frame search, one frame store read per cycle.
// After reset the shadow memory is cleared one entry a cycle, with s_tready low.
// A record waits in the output register while the next word is taken.
module read_memory_size_profiler_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [rmsp_pkg::IN_W-1:0]  s_tdata,   // mode, addr, length, func_id, cost
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rmsp_pkg::OUT_W-1:0] m_tdata    // status, rec_func_id, rec_ts, rec_rms, rec_cost
);
  import rmsp_pkg::*;

  state_t state, state_next;

  logic [ADDR_BITS-1:0] clr_addr, clr_addr_next;
  logic [DEPTH_W-1:0]   depth, depth_next;
  logic [31:0]          cnt, cnt_next;
  mode_t                mode_r, mode_r_next;
  logic [ADDR_BITS-1:0] cur, cur_next;
  logic [LEN_W-1:0]     rem, rem_next;
  logic [LEN_W-1:0]     len_r, len_r_next;
  logic [31:0]          cost_r, cost_r_next;
  logic                 charge, charge_next;
  frame_t               topw, topw_next;
  logic [TS_W-1:0]      tsw_r, tsw_r_next;
  logic [IDX_W-1:0]     j, j_next;
  result_t              pend, pend_next;
  result_t              out_r;
  logic                 out_v;

  logic [2:0]           in_mode;
  logic [ADDR_BITS-1:0] in_addr;
  logic [LEN_W-1:0]     in_len_raw, in_len;
  logic [FID_W-1:0]     in_fid;
  logic [31:0]          in_cost;
  logic [IDX_W-1:0]     top_idx;

  logic                 sh_we;
  logic [ADDR_BITS-1:0] sh_waddr;
  logic [TS_W-1:0]      sh_wdata;
  logic [TS_W-1:0]      sh_rdata;
  logic                 fr_we;
  logic [IDX_W-1:0]     fr_waddr, fr_raddr;
  frame_t               fr_wdata, fr_rdata;
  logic                 out_free;
  logic                 last_byte;

  assign in_mode    = s_tdata[2:0];
  assign in_addr    = s_tdata[18:3];
  assign in_len_raw = s_tdata[30:19];
  assign in_fid     = s_tdata[46:31];
  assign in_cost    = s_tdata[78:47];
  assign in_len     = (in_len_raw > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : in_len_raw;

  assign top_idx   = IDX_W'(depth - DEPTH_W'(1));
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !out_v || m_tready;
  assign last_byte = (rem == LEN_W'(1));
  assign m_tvalid  = out_v;
  assign m_tdata   = {{(OUT_W - $bits(result_t)){1'b0}}, out_r};

  rmsp_ram #(.WIDTH(TS_W), .DEPTH(2 ** ADDR_BITS)) u_shadow (
    .clk  (clk),
    .we   (sh_we),
    .waddr(sh_waddr),
    .wdata(sh_wdata),
    .raddr(cur),
    .rdata(sh_rdata)
  );

  rmsp_ram #(.WIDTH(FRAME_W), .DEPTH(STACK_DEPTH)) u_frames (
    .clk  (clk),
    .we   (fr_we),
    .waddr(fr_waddr),
    .wdata(fr_wdata),
    .raddr(fr_raddr),
    .rdata(fr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      depth    <= '0;
      cnt      <= '0;
      out_v    <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      depth    <= depth_next;
      cnt      <= cnt_next;
      if (state == ST_EMIT && out_free) begin
        out_v <= 1'b1;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_r_next;
    cur    <= cur_next;
    rem    <= rem_next;
    len_r  <= len_r_next;
    cost_r <= cost_r_next;
    charge <= charge_next;
    topw   <= topw_next;
    tsw_r  <= tsw_r_next;
    j      <= j_next;
    pend   <= pend_next;
    if (state == ST_EMIT && out_free) begin
      out_r <= pend;
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    depth_next    = depth;
    cnt_next      = cnt;
    mode_r_next   = mode_r;
    cur_next      = cur;
    rem_next      = rem;
    len_r_next    = len_r;
    cost_r_next   = cost_r;
    charge_next   = charge;
    topw_next     = topw;
    tsw_r_next    = tsw_r;
    j_next        = j;
    pend_next     = pend;
    sh_we         = 1'b0;
    sh_waddr      = cur;
    sh_wdata      = cnt;
    fr_we         = 1'b0;
    fr_waddr      = top_idx;
    fr_wdata      = topw;
    fr_raddr      = top_idx;

    unique case (state)
      ST_CLEAR: begin
        sh_we         = 1'b1;
        sh_waddr      = clr_addr;
        sh_wdata      = '0;
        clr_addr_next = clr_addr + ADDR_BITS'(1);
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_tvalid) begin
          mode_r_next = mode_t'(in_mode);
          cur_next    = in_addr;
          rem_next    = in_len;
          len_r_next  = in_len;
          cost_r_next = in_cost;
          charge_next = (depth != '0);
          pend_next   = '0;
          priority case (in_mode)
            MODE_CALL: begin
              if (depth == DEPTH_W'(STACK_DEPTH)) begin
                pend_next.status = STAT_OVF;
                state_next       = ST_EMIT;
              end else begin
                fr_we      = 1'b1;
                fr_waddr   = IDX_W'(depth);
                fr_wdata   = '{func: in_fid, ts: cnt + 32'd1, rms: '0, cost: '0};
                cnt_next   = cnt + 32'd1;
                depth_next = depth + DEPTH_W'(1);
              end
            end
            MODE_RET: begin
              if (depth == '0) begin
                pend_next.status = STAT_EMPTY;
                state_next       = ST_EMIT;
              end else begin
                state_next = ST_RET_A;
              end
            end
            MODE_ADD: begin
              if (depth == '0) begin
                pend_next.status = STAT_EMPTY;
                state_next       = ST_EMIT;
              end else begin
                state_next = ST_ADD;
              end
            end
            MODE_READ: begin
              if (depth != '0) begin
                state_next = ST_TOP;
              end else if (in_len == '0) begin
                pend_next.status = STAT_EMPTY;
                state_next       = ST_EMIT;
              end else begin
                pend_next.status = STAT_EMPTY;
                state_next       = ST_B_ISSUE;
              end
            end
            MODE_WRITE: begin
              charge_next = 1'b0;
              if (in_len != '0) begin
                state_next = ST_B_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end

      ST_RET_A: begin
        pend_next.status  = STAT_REC;
        pend_next.func_id = fr_rdata.func;
        pend_next.ts      = fr_rdata.ts;
        pend_next.rms     = fr_rdata.rms;
        pend_next.cost    = fr_rdata.cost + cost_r;
        depth_next        = depth - DEPTH_W'(1);
        fr_raddr          = IDX_W'(depth - DEPTH_W'(2));
        state_next        = (depth == DEPTH_W'(1)) ? ST_EMIT : ST_RET_B;
      end

      ST_RET_B: begin
        fr_we         = 1'b1;
        fr_waddr      = top_idx;
        fr_wdata      = fr_rdata;
        fr_wdata.rms  = fr_rdata.rms + pend.rms;
        fr_wdata.cost = fr_rdata.cost + pend.cost;
        state_next    = ST_EMIT;
      end

      ST_ADD: begin
        fr_we        = 1'b1;
        fr_wdata     = fr_rdata;
        fr_wdata.rms = fr_rdata.rms + 32'(len_r);
        state_next   = ST_IDLE;
      end

      ST_TOP: begin
        topw_next  = fr_rdata;
        state_next = (rem == '0) ? ST_WB : ST_B_ISSUE;
      end

      ST_B_ISSUE: begin
        state_next = ST_B_EVAL;
      end

      ST_B_EVAL: begin
        sh_we    = 1'b1;
        cur_next = cur + ADDR_BITS'(1);
        rem_next = rem - LEN_W'(1);
        if (last_byte) begin
          state_next = charge ? ST_WB :
                       (mode_r == MODE_READ) ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_B_ISSUE;
        end
        if (charge && sh_rdata < topw.ts) begin
          topw_next.rms = topw.rms + 32'd1;
          if (sh_rdata != '0 && depth >= DEPTH_W'(3)) begin
            tsw_r_next = sh_rdata;
            j_next     = top_idx - IDX_W'(1);
            fr_raddr   = top_idx - IDX_W'(1);
            cur_next   = cur;
            rem_next   = rem;
            state_next = ST_S_CHK;
          end
        end
      end

      ST_S_CHK: begin
        if (fr_rdata.ts <= tsw_r || j == IDX_W'(1)) begin
          if (fr_rdata.ts <= tsw_r) begin
            fr_we        = 1'b1;
            fr_waddr     = j;
            fr_wdata     = fr_rdata;
            fr_wdata.rms = fr_rdata.rms - 32'd1;
          end
          cur_next = cur + ADDR_BITS'(1);
          rem_next = rem - LEN_W'(1);
          state_next = last_byte ? ST_WB : ST_B_ISSUE;
        end else begin
          j_next   = j - IDX_W'(1);
          fr_raddr = j - IDX_W'(1);
        end
      end

      ST_WB: begin
        fr_we      = 1'b1;
        state_next = ST_IDLE;
      end

      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ src/rmsp_checker.sv @@
// Port-level checks of the profiler top level, bound to it.
module rmsp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [119:0] m_tdata
);
  import rmsp_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result word changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == STAT_REC || m_tdata[1:0] == STAT_OVF ||
                  m_tdata[1:0] == STAT_EMPTY))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != STAT_REC |-> m_tdata[119:2] == '0)
    else $error("error word carries nonzero fields");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input taken during shadow clear");

endmodule

bind read_memory_size_profiler_top rmsp_checker u_rmsp_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

@@ verif/tb.sv @@
// Testbench for read_memory_size_profiler_top: random and directed event streams checked
// against a behavioral profiler model.
module tb;
  import rmsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  read_memory_size_profiler_top dut (.*);

  always #10 clk = ~clk;

  // profiler model state
  logic [31:0] shadow [0:65535];
  logic [15:0] fr_func [0:STACK_DEPTH-1];
  logic [31:0] fr_ts   [0:STACK_DEPTH-1];
  logic [31:0] fr_rms  [0:STACK_DEPTH-1];
  logic [31:0] fr_cost [0:STACK_DEPTH-1];
  int          depth = 0;
  logic [31:0] calls = '0;

  logic [IN_W-1:0] pending_words[$];
  result_t         expected_recs[$];
  int              errors = 0;
  bit              calm = 1'b0;
  int              big_reads = 0;

  function automatic void push_rec(status_t st, logic [15:0] f, logic [31:0] ts,
                                   logic [31:0] rms, logic [31:0] c);
    result_t r;
    r.status  = st;
    r.func_id = f;
    r.ts      = ts;
    r.rms     = rms;
    r.cost    = c;
    expected_recs.push_back(r);
  endfunction

  function automatic void stamp_range(logic [15:0] addr, int len, bit charge);
    logic [15:0] a;
    logic [31:0] tsw;
    int top;
    for (int i = 0; i < len; i++) begin
      a = addr + i[15:0];
      if (charge) begin
        top = depth - 1;
        tsw = shadow[a];
        if (tsw < fr_ts[top]) begin
          fr_rms[top] += 1;
          if (tsw != 0) begin
            for (int j = top; j > 0; j--) begin
              if (fr_ts[j] <= tsw) begin
                fr_rms[j] -= 1;
                break;
              end
            end
          end
        end
      end
      shadow[a] = calls;
    end
  endfunction

  // updates the model and queues the word for the driver
  function automatic void profile_event(logic [2:0] mode, logic [15:0] addr, logic [11:0] len,
                                        logic [15:0] fid, logic [31:0] c);
    int top;
    pending_words.push_back({1'b0, c, fid, len, addr, mode});
    case (mode)
      MODE_CALL: begin
        if (depth >= STACK_DEPTH) push_rec(STAT_OVF, '0, '0, '0, '0);
        else begin
          calls += 1;
          fr_func[depth] = fid;
          fr_ts[depth]   = calls;
          fr_rms[depth]  = '0;
          fr_cost[depth] = '0;
          depth++;
        end
      end
      MODE_RET: begin
        if (depth == 0) push_rec(STAT_EMPTY, '0, '0, '0, '0);
        else begin
          top = depth - 1;
          fr_cost[top] += c;
          push_rec(STAT_REC, fr_func[top], fr_ts[top], fr_rms[top], fr_cost[top]);
          if (top > 0) begin
            fr_rms[top-1]  += fr_rms[top];
            fr_cost[top-1] += fr_cost[top];
          end
          depth = top;
        end
      end
      MODE_READ: begin
        stamp_range(addr, int'(len), depth != 0);
        if (depth == 0) push_rec(STAT_EMPTY, '0, '0, '0, '0);
      end
      MODE_WRITE: stamp_range(addr, int'(len), 1'b0);
      MODE_ADD: begin
        if (depth == 0) push_rec(STAT_EMPTY, '0, '0, '0, '0);
        else fr_rms[depth-1] += {20'd0, len};
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] pick_addr();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 127) + 16'hFFC0);
  endfunction

  function automatic logic [11:0] pick_len(bit is_read);
    if (big_reads < 4 && $urandom_range(0, 199) == 0) begin
      big_reads++;
      return 12'($urandom_range(3000, 4095));
    end
    if (!is_read && $urandom_range(0, 29) == 0) return 12'($urandom_range(100, 600));
    return 12'($urandom_range(0, 12));
  endfunction

  // driver
  int s_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_gap > 0) begin
        s_gap <= s_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        s_tdata  <= pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_gap    <= pick_gap();
        if ($urandom_range(0, 59) == 0) calm <= ~calm;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink stalls
  int m_stall = 0;
  always @(posedge clk) begin
    if (m_stall > 0) begin
      m_stall  <= m_stall - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      m_stall  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(result_t)-1:0];
      if (expected_recs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected record %h", got);
      end else begin
        want = expected_recs.pop_front();
        if (got.status !== want.status || got.func_id !== want.func_id ||
            got.ts !== want.ts || got.rms !== want.rms || got.cost !== want.cost) begin
          errors++;
          if (errors <= 10)
            $display({"record mismatch: exp st=%0d fid=%h ts=%h rms=%h cost=%h, ",
                      "got st=%0d fid=%h ts=%h rms=%h cost=%h"},
                     want.status, want.func_id, want.ts, want.rms, want.cost,
                     got.status, got.func_id, got.ts, got.rms, got.cost);
        end
      end
    end
  end

  initial begin
    int n, r;
    for (int i = 0; i < 65536; i++) shadow[i] = '0;
    // empty stack cases, ignored modes, wrap, then reads, writes, adds and returns under two calls
    profile_event(MODE_WRITE, 16'h0000, 12'd0, 16'h0, 32'h0);
    profile_event(MODE_WRITE, 16'hFFF8, 12'd16, 16'hFFFF, 32'hFFFFFFFF);
    profile_event(MODE_READ, 16'h1234, 12'd3, 16'h0, 32'h0);
    profile_event(MODE_RET, 16'h0, 12'd0, 16'h0, 32'h5);
    profile_event(MODE_ADD, 16'h0, 12'd7, 16'h0, 32'h0);
    profile_event(3'd5, 16'hFFFF, 12'hFFF, 16'hFFFF, 32'hFFFFFFFF);
    profile_event(3'd6, 16'h0, 12'd1, 16'h0, 32'h0);
    profile_event(3'd7, 16'h0, 12'd1, 16'h0, 32'h0);
    profile_event(MODE_CALL, 16'h0, 12'd0, 16'hFFFF, 32'h0);
    profile_event(MODE_READ, 16'hFFF0, 12'd32, 16'h0, 32'h0);
    profile_event(MODE_READ, 16'h0000, 12'd0, 16'h0, 32'h0);
    profile_event(MODE_CALL, 16'h0, 12'd0, 16'h0000, 32'h0);
    profile_event(MODE_READ, 16'hFFF4, 12'd16, 16'h0, 32'h0);
    profile_event(MODE_WRITE, 16'h0100, 12'd8, 16'h0, 32'h0);
    profile_event(MODE_ADD, 16'h0, 12'hFFF, 16'h0, 32'h0);
    profile_event(MODE_ADD, 16'h0, 12'h0, 16'h0, 32'h0);
    profile_event(MODE_RET, 16'h0, 12'd0, 16'h0, 32'hFFFFFFFF);
    profile_event(MODE_READ, 16'hF000, 12'hFFF, 16'h0, 32'h0);
    profile_event(MODE_RET, 16'h0, 12'd0, 16'h0, 32'h00000001);
    profile_event(MODE_RET, 16'h0, 12'd0, 16'h0, 32'h0);

    n = 0;
    while (n < 800) begin
      if (n == 400) begin
        while (depth < STACK_DEPTH)
          profile_event(MODE_CALL, '0, '0, 16'($urandom), 32'($urandom));
        profile_event(MODE_CALL, '0, '0, 16'($urandom), '0);
        profile_event(MODE_CALL, '0, '0, 16'($urandom), '0);
        n += 2;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        profile_event(3'($urandom_range(5, 7)), 16'($urandom), 12'($urandom),
                      16'($urandom), 32'($urandom));
        n++;
        continue;
      end
      if (r < 24 && (depth < 12 || r < 10))
        profile_event(MODE_CALL, 16'($urandom), 12'($urandom), 16'($urandom), 32'($urandom));
      else if (r < 42 && (depth > 0 || r < 26))
        profile_event(MODE_RET, 16'($urandom), 12'($urandom), 16'($urandom), 32'($urandom));
      else if (r < 72)
        profile_event(MODE_READ, pick_addr(), pick_len(1'b1), 16'($urandom), 32'($urandom));
      else if (r < 88)
        profile_event(MODE_WRITE, pick_addr(), pick_len(1'b0), 16'($urandom), 32'($urandom));
      else
        profile_event(MODE_ADD, 16'($urandom), 12'($urandom), 16'($urandom), 32'($urandom));
      n++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && !s_tvalid);
    wait (expected_recs.size() == 0);
    repeat (20000) @(posedge clk);
    if (errors == 0 && expected_recs.size() == 0) begin
      $display("read_memory_size_profiler_top verification clean");
    end else begin
      $display("read_memory_size_profiler_top verification failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("read_memory_size_profiler_top verification failed");
    $finish;
  end

endmodule

@@ files.f @@
src/rmsp_pkg.sv
src/rmsp_ram.sv
src/read_memory_size_profiler_top.sv
src/rmsp_checker.sv
verif/tb.sv
